// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CGB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/cgb_pkg.sv =====
// Types and codes for the cursor gap buffer editor.
package cgb_pkg;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_LEFT   = 3'd1;
    localparam logic [2:0] KIND_RIGHT  = 3'd2;
    localparam logic [2:0] KIND_BACK   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam int FIELD_LEN_W = 13;
    localparam int FIELD_IDX_W = 12;

    typedef struct packed {
        logic [2:0]             kind;
        logic [7:0]             char_in;
        logic [FIELD_IDX_W-1:0] read_index;
    } cgb_in_t;

    typedef struct packed {
        logic [7:0]             char_out;
        logic                   read_valid;
        logic [FIELD_LEN_W-1:0] text_length;
        logic [FIELD_LEN_W-1:0] cursor_pos;
        logic [1:0]             status;
    } cgb_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_MEM
    } cgb_state_t;

endpackage

// ===== hdl/cgb_text_ram.sv =====
// Character store: one write port, one read port with registered read data.
module cgb_text_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/cursor_gap_buffer_editor_unit.sv =====
// Cursor gap buffer line editor: two stacks in one character memory.
// Insert, backspace, ignored ops, out-of-range reads: result valid in the cycle after transfer.
// Cursor moves and in-range reads: the memory read, then in ST_MEM write-back (moves) and result.
// One item in flight: s_ready needs ST_IDLE and an output register that is free or being taken.
// The registered read data of the character memory is why these ops pass through ST_MEM.
// Reset clears the cursor counts and handshake state; memory contents are not cleared.
module cursor_gap_buffer_editor_unit #(
    parameter int CAPACITY = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cgb_pkg::cgb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cgb_pkg::cgb_out_t m_data
);
    import cgb_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > FIELD_IDX_W) ? CW : FIELD_IDX_W) + 1;

    cgb_state_t state_reg, state_next;

    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic          pend_read_reg, pend_read_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          m_valid_reg, m_valid_next;
    cgb_out_t      m_data_reg, m_data_next;

    logic          s_xfer;
    logic          mem_op;
    logic [1:0]    dec_status;
    logic [CW-1:0] dec_left;
    logic [CW-1:0] dec_right;
    logic          dec_wr;
    logic [AW-1:0] dec_rd_addr;
    logic [AW-1:0] dec_mv_addr;

    logic [WW-1:0] len_w;
    logic [WW-1:0] left_w;
    logic [WW-1:0] idx_w;
    logic [WW-1:0] gap_w;
    logic [WW-1:0] rd_pos_w;
    logic [WW-1:0] dec_len_w;
    logic [CW-1:0] left_m1;
    logic [CW-1:0] top_addr;
    logic [CW-1:0] top_m1;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    assign len_w    = WW'(left_reg) + WW'(right_reg);
    assign left_w   = WW'(left_reg);
    assign idx_w    = WW'(s_data.read_index);
    assign gap_w    = WW'(CAPACITY) - len_w;
    assign rd_pos_w = (idx_w < left_w) ? idx_w : idx_w + gap_w;
    assign left_m1  = left_reg - CW'(1);
    assign top_addr = CW'(CAPACITY) - right_reg;
    assign top_m1   = CW'(CAPACITY - 1) - right_reg;

    assign s_xfer    = s_valid && s_ready;
    assign dec_len_w = WW'(dec_left) + WW'(dec_right);

    always_comb begin
        mem_op         = 1'b0;
        dec_status     = STATUS_DONE;
        dec_left       = left_reg;
        dec_right      = right_reg;
        dec_wr         = 1'b0;
        dec_rd_addr    = rd_pos_w[AW-1:0];
        dec_mv_addr    = left_reg[AW-1:0];
        pend_read_next = 1'b0;
        unique case (s_data.kind)
            KIND_INSERT: begin
                if (len_w == WW'(CAPACITY)) begin
                    dec_status = STATUS_FULL;
                end else begin
                    dec_wr   = 1'b1;
                    dec_left = left_reg + CW'(1);
                end
            end
            KIND_LEFT: begin
                if (left_reg == '0) begin
                    dec_status = STATUS_IGNORED;
                end else begin
                    mem_op      = 1'b1;
                    dec_rd_addr = left_m1[AW-1:0];
                    dec_mv_addr = top_m1[AW-1:0];
                    dec_left    = left_m1;
                    dec_right   = right_reg + CW'(1);
                end
            end
            KIND_RIGHT: begin
                if (right_reg == '0) begin
                    dec_status = STATUS_IGNORED;
                end else begin
                    mem_op      = 1'b1;
                    dec_rd_addr = top_addr[AW-1:0];
                    dec_left    = left_reg + CW'(1);
                    dec_right   = right_reg - CW'(1);
                end
            end
            KIND_BACK: begin
                if (left_reg == '0) begin
                    dec_status = STATUS_IGNORED;
                end else begin
                    dec_left = left_m1;
                end
            end
            KIND_READ: begin
                if (idx_w < len_w) begin
                    mem_op         = 1'b1;
                    pend_read_next = 1'b1;
                end
            end
            default: begin
                dec_status = STATUS_IGNORED;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && mem_op) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        left_next    = s_xfer ? dec_left : left_reg;
        right_next   = s_xfer ? dec_right : right_reg;
        wr_addr_next = s_xfer ? dec_mv_addr : wr_addr_reg;

        ram_re    = s_xfer && mem_op;
        ram_we    = (s_xfer && dec_wr) || ((state_reg == ST_MEM) && !pend_read_reg);
        ram_waddr = (state_reg == ST_MEM) ? wr_addr_reg : left_reg[AW-1:0];
        ram_wdata = (state_reg == ST_MEM) ? ram_rdata : s_data.char_in;

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (state_reg == ST_MEM) begin
            m_valid_next            = 1'b1;
            m_data_next.char_out    = pend_read_reg ? ram_rdata : 8'd0;
            m_data_next.read_valid  = pend_read_reg;
            m_data_next.text_length = len_w[FIELD_LEN_W-1:0];
            m_data_next.cursor_pos  = left_w[FIELD_LEN_W-1:0];
            m_data_next.status      = STATUS_DONE;
        end else if (s_xfer && !mem_op) begin
            m_valid_next            = 1'b1;
            m_data_next.char_out    = 8'd0;
            m_data_next.read_valid  = 1'b0;
            m_data_next.text_length = dec_len_w[FIELD_LEN_W-1:0];
            m_data_next.cursor_pos  = FIELD_LEN_W'(dec_left);
            m_data_next.status      = dec_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            m_valid_reg   <= 1'b0;
            pend_read_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            m_valid_reg <= m_valid_next;
            if (s_xfer) begin
                pend_read_reg <= pend_read_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cgb_text_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dec_rd_addr),
        .rdata (ram_rdata)
    );

    `CGB_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1, len_w <= WW'(CAPACITY))
    `CGB_ASSERT_NOW(a_mem_no_xfer, aclk, aresetn, state_reg == ST_MEM, !s_ready)
    `CGB_ASSERT_NEXT(a_mem_enter, aclk, aresetn, s_xfer && mem_op, state_reg == ST_MEM)
    `CGB_ASSERT_NEXT(a_mem_result, aclk, aresetn, state_reg == ST_MEM, m_valid_reg)

endmodule
